FILE: sv/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Types, codes and default sizes shared by the open-address hash table files.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int unsigned SLOTS_DEF      = 64;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned STEP_BITS  = 6;
  localparam int unsigned HASH_BITS  = 32;
  localparam int unsigned HOME_DIGIT = 4;
  localparam int unsigned HOME_STEPS = HASH_BITS / HOME_DIGIT;
  localparam int unsigned OCC_BITS   = 7;
  localparam int unsigned STATE_BITS = 2;

  localparam int unsigned STEP_CAND [8] = '{3, 5, 7, 11, 13, 17, 19, 23};

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;

  localparam logic [1:0] RES_OK      = 2'd0;
  localparam logic [1:0] RES_EXISTS  = 2'd1;
  localparam logic [1:0] RES_MISSING = 2'd2;
  localparam logic [1:0] RES_FULL    = 2'd3;

  localparam logic [STATE_BITS-1:0] ST_FREE    = 2'd0;
  localparam logic [STATE_BITS-1:0] ST_BUSY    = 2'd1;
  localparam logic [STATE_BITS-1:0] ST_DELETED = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [31:0]         found_value;
    logic [OCC_BITS-1:0] occupancy;
  } out_item_t;

endpackage

FILE: sv/open_address_hash_table.sv
// ----------------------------------------------------------------------------
// open_address_hash_table
// Fixed-capacity key/value table with fixed-stride probing and tombstones.
//
//   channel   ports                      request
//   in        in_valid  in_stall  in_data  mode, key, key_hash, value
//   out       out_valid out_stall out_data status, found_value, occupancy
//   cfg       cfg_we    cfg_wdata          probe_step
//
// a request issues one slot store read per probe cycle;
// a non power-of-two SLOTS first reduces the hash to the home slot
// after reset a clear pass marks every slot free before the first request
// the next request is taken while a result waits in the output register
// ----------------------------------------------------------------------------
module open_address_hash_table #(
  parameter int unsigned SLOTS      = oaht_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BITS   = oaht_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  oaht_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output oaht_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [oaht_pkg::STEP_BITS-1:0]   cfg_wdata
);

  localparam int unsigned SLOT_W    = $clog2(SLOTS);
  localparam int unsigned ENT_W     = oaht_pkg::STATE_BITS + KEY_BITS + VALUE_BITS;
  localparam int unsigned STEP_VALS = 1 << oaht_pkg::STEP_BITS;
  localparam int unsigned DEF_STEP =
    (SLOTS % oaht_pkg::STEP_CAND[0] != 0) ? oaht_pkg::STEP_CAND[0] :
    (SLOTS % oaht_pkg::STEP_CAND[1] != 0) ? oaht_pkg::STEP_CAND[1] :
    (SLOTS % oaht_pkg::STEP_CAND[2] != 0) ? oaht_pkg::STEP_CAND[2] :
    (SLOTS % oaht_pkg::STEP_CAND[3] != 0) ? oaht_pkg::STEP_CAND[3] :
    (SLOTS % oaht_pkg::STEP_CAND[4] != 0) ? oaht_pkg::STEP_CAND[4] :
    (SLOTS % oaht_pkg::STEP_CAND[5] != 0) ? oaht_pkg::STEP_CAND[5] :
    (SLOTS % oaht_pkg::STEP_CAND[6] != 0) ? oaht_pkg::STEP_CAND[6] :
    (SLOTS % oaht_pkg::STEP_CAND[7] != 0) ? oaht_pkg::STEP_CAND[7] : 1;

  logic [oaht_pkg::STEP_BITS-1:0] step_r, step_nxt;
  logic [SLOT_W-1:0]              step_tab [STEP_VALS];
  logic [SLOT_W-1:0]              step_mod;
  logic                           out_valid_r, out_valid_nxt;
  oaht_pkg::out_item_t            out_data_r, out_data_nxt;
  logic                           res_valid;
  logic                           res_take;
  oaht_pkg::out_item_t            res_data;
  logic                           mem_we;
  logic [SLOT_W-1:0]              mem_waddr;
  logic [ENT_W-1:0]               mem_wdata;
  logic                           mem_re;
  logic [SLOT_W-1:0]              mem_raddr;
  logic [ENT_W-1:0]               mem_rdata;

  // stride reduced modulo the slot count
  for (genvar g = 0; g < STEP_VALS; g++) begin : g_step
    assign step_tab[g] = SLOT_W'(g % SLOTS);
  end

  assign step_mod = step_tab[step_r];
  assign step_nxt = cfg_we ? cfg_wdata : step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= oaht_pkg::STEP_BITS'(DEF_STEP);
    end else begin
      step_r <= step_nxt;
    end
  end

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  oaht_ctrl #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .step_mod  (step_mod),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_data  (res_data)
  );

  oaht_mem #(
    .DEPTH (SLOTS),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: sv/oaht_mem.sv
// ----------------------------------------------------------------------------
// oaht_mem
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module oaht_mem #(
  parameter int unsigned DEPTH = oaht_pkg::SLOTS_DEF,
  parameter int unsigned WIDTH = 2 + oaht_pkg::KEY_BITS_DEF + oaht_pkg::VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_q[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/oaht_ctrl.sv
// ----------------------------------------------------------------------------
// oaht_ctrl
// Request sequencer: clear pass, home slot reduction, pipelined probing,
// decision and write-back into the slot store.
// ----------------------------------------------------------------------------
module oaht_ctrl #(
  parameter int unsigned SLOTS      = oaht_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BITS   = oaht_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  oaht_pkg::in_item_t             in_data,
  input  logic [$clog2(SLOTS)-1:0]       step_mod,
  output logic                           mem_we,
  output logic [$clog2(SLOTS)-1:0]       mem_waddr,
  output logic [oaht_pkg::STATE_BITS+KEY_BITS+VALUE_BITS-1:0] mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(SLOTS)-1:0]       mem_raddr,
  input  logic [oaht_pkg::STATE_BITS+KEY_BITS+VALUE_BITS-1:0] mem_rdata,
  output logic                           res_valid,
  input  logic                           res_take,
  output oaht_pkg::out_item_t            res_data
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned HCNT_W = $clog2(oaht_pkg::HOME_STEPS);
  localparam bit          POW2   = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [SLOT_W:0]   SLOTS_X = (SLOT_W + 1)'(SLOTS);
  localparam logic [SLOT_W-1:0] LAST    = SLOT_W'(SLOTS - 1);
  localparam logic [HCNT_W-1:0] HLAST   = HCNT_W'(oaht_pkg::HOME_STEPS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HOME  = 5'b00100,
    S_PROBE = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  oaht_pkg::in_item_t              req_r, req_nxt;
  logic [oaht_pkg::HASH_BITS-1:0]  sh_r, sh_nxt;
  logic [SLOT_W-1:0]               rem_r, rem_nxt;
  logic [HCNT_W-1:0]               hcnt_r, hcnt_nxt;
  logic [SLOT_W-1:0]               slot_r, slot_nxt;
  logic [SLOT_W:0]                 iss_r, iss_nxt;
  logic                            rd_v_r, rd_v_nxt;
  logic [SLOT_W-1:0]               rd_idx_r, rd_idx_nxt;
  logic                            rd_last_r, rd_last_nxt;
  logic                            tomb_v_r, tomb_v_nxt;
  logic [SLOT_W-1:0]               tomb_r, tomb_nxt;
  logic [CNT_W-1:0]                busy_r, busy_nxt;
  oaht_pkg::out_item_t             res_r, res_nxt;

  logic [oaht_pkg::STATE_BITS-1:0] e_st;
  logic [KEY_BITS-1:0]             e_key;
  logic [VALUE_BITS-1:0]           e_val;
  logic [KEY_BITS-1:0]             key_k;
  logic                            hit;
  logic                            done;
  logic [1:0]                      status;
  logic [31:0]                     found;
  logic [SLOT_W:0]                 sum;
  logic [SLOT_W:0]                 tmp;
  logic [SLOT_W-1:0]               rem_w;
  logic [oaht_pkg::HASH_BITS-1:0]  sh_w;
  logic                            tomb_any;
  logic [SLOT_W-1:0]               tomb_idx;

  assign e_st  = mem_rdata[oaht_pkg::STATE_BITS+KEY_BITS+VALUE_BITS-1 -: oaht_pkg::STATE_BITS];
  assign e_key = mem_rdata[KEY_BITS+VALUE_BITS-1 -: KEY_BITS];
  assign e_val = mem_rdata[VALUE_BITS-1:0];
  assign key_k = KEY_BITS'(req_r.key);
  assign hit   = (e_st == oaht_pkg::ST_BUSY) && (e_key == key_k);
  assign tomb_any = tomb_v_r || (e_st == oaht_pkg::ST_DELETED);
  assign tomb_idx = tomb_v_r ? tomb_r : rd_idx_r;

  always_comb begin
    sum = {1'b0, slot_r} + {1'b0, step_mod};
    if (sum >= SLOTS_X) begin
      sum = sum - SLOTS_X;
    end
  end

  // home slot: remainder of the hash, four bits a cycle
  always_comb begin
    rem_w = rem_r;
    sh_w  = sh_r;
    for (int b = 0; b < oaht_pkg::HOME_DIGIT; b++) begin
      tmp = {rem_w, sh_w[oaht_pkg::HASH_BITS-1]};
      if (tmp >= SLOTS_X) begin
        tmp = tmp - SLOTS_X;
      end
      rem_w = tmp[SLOT_W-1:0];
      sh_w  = {sh_w[oaht_pkg::HASH_BITS-2:0], 1'b0};
    end
  end

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    sh_nxt      = sh_r;
    rem_nxt     = rem_r;
    hcnt_nxt    = hcnt_r;
    slot_nxt    = slot_r;
    iss_nxt     = iss_r;
    rd_v_nxt    = 1'b0;
    rd_idx_nxt  = rd_idx_r;
    rd_last_nxt = rd_last_r;
    tomb_v_nxt  = tomb_v_r;
    tomb_nxt    = tomb_r;
    busy_nxt    = busy_r;
    res_nxt     = res_r;
    in_stall    = 1'b1;
    res_valid   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = rd_idx_r;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = slot_r;
    done        = 1'b0;
    status      = oaht_pkg::RES_MISSING;
    found       = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = slot_r;
        mem_wdata = {oaht_pkg::ST_FREE, (KEY_BITS + VALUE_BITS)'(0)};
        slot_nxt  = slot_r + 1'b1;
        if (slot_r == LAST) begin
          slot_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          req_nxt    = in_data;
          iss_nxt    = '0;
          tomb_v_nxt = 1'b0;
          sh_nxt     = in_data.key_hash;
          rem_nxt    = '0;
          hcnt_nxt   = '0;
          if (POW2) begin
            slot_nxt  = in_data.key_hash[SLOT_W-1:0];
            state_nxt = S_PROBE;
          end else begin
            state_nxt = S_HOME;
          end
        end
      end
      S_HOME: begin
        rem_nxt  = rem_w;
        sh_nxt   = sh_w;
        hcnt_nxt = hcnt_r + 1'b1;
        if (hcnt_r == HLAST) begin
          slot_nxt  = rem_w;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (iss_r != SLOTS_X) begin
          mem_re      = 1'b1;
          slot_nxt    = sum[SLOT_W-1:0];
          iss_nxt     = iss_r + 1'b1;
          rd_v_nxt    = 1'b1;
          rd_idx_nxt  = slot_r;
          rd_last_nxt = (iss_r == {1'b0, LAST});
        end
        if (rd_v_r) begin
          case (req_r.mode)
            oaht_pkg::MODE_INSERT: begin
              if (hit) begin
                done   = 1'b1;
                status = oaht_pkg::RES_EXISTS;
              end else if (e_st == oaht_pkg::ST_BUSY || e_st == oaht_pkg::ST_DELETED) begin
                if (e_st == oaht_pkg::ST_DELETED && !tomb_v_r) begin
                  tomb_v_nxt = 1'b1;
                  tomb_nxt   = rd_idx_r;
                end
                if (rd_last_r) begin
                  done = 1'b1;
                  if (tomb_any) begin
                    status = oaht_pkg::RES_OK;
                  end else begin
                    status = oaht_pkg::RES_FULL;
                  end
                end
              end else begin
                done   = 1'b1;
                status = oaht_pkg::RES_OK;
              end
              if (done && status == oaht_pkg::RES_OK) begin
                mem_we    = 1'b1;
                mem_waddr = tomb_idx;
                mem_wdata = {oaht_pkg::ST_BUSY, key_k, VALUE_BITS'(req_r.value)};
                busy_nxt  = busy_r + 1'b1;
              end
            end
            oaht_pkg::MODE_DELETE: begin
              if (hit) begin
                done      = 1'b1;
                status    = oaht_pkg::RES_OK;
                mem_we    = 1'b1;
                mem_waddr = rd_idx_r;
                mem_wdata = {oaht_pkg::ST_DELETED, e_key, e_val};
                if (busy_r != '0) begin
                  busy_nxt = busy_r - 1'b1;
                end
              end else if (rd_last_r) begin
                done = 1'b1;
              end
            end
            oaht_pkg::MODE_FIND: begin
              if (hit) begin
                done   = 1'b1;
                status = oaht_pkg::RES_OK;
                found  = 32'(e_val);
              end else if (e_st != oaht_pkg::ST_BUSY && e_st != oaht_pkg::ST_DELETED) begin
                done = 1'b1;
              end else if (rd_last_r) begin
                done = 1'b1;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
          if (done) begin
            rd_v_nxt              = 1'b0;
            res_nxt.status        = status;
            res_nxt.found_value   = found;
            res_nxt.occupancy     = oaht_pkg::OCC_BITS'(busy_nxt);
            state_nxt             = S_OUT;
          end
        end
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        slot_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      slot_r  <= '0;
      busy_r  <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      busy_r  <= busy_nxt;
      rd_v_r  <= rd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    sh_r      <= sh_nxt;
    rem_r     <= rem_nxt;
    hcnt_r    <= hcnt_nxt;
    iss_r     <= iss_nxt;
    rd_idx_r  <= rd_idx_nxt;
    rd_last_r <= rd_last_nxt;
    tomb_v_r  <= tomb_v_nxt;
    tomb_r    <= tomb_nxt;
    res_r     <= res_nxt;
  end

  assign res_data = res_r;

endmodule
